/* sv/acs_pkg.sv */
// ============================================================================
// acs_pkg: shared types and constants for the column run segmenter
// Holds the classified column item passed from the front to the back and
// the field widths fixed by the interface.
// ============================================================================
`default_nettype none

package acs_pkg;

    // Fixed field widths
    localparam int ROW_FIELDS = 8;
    localparam int CHAR_W     = 8;
    localparam int ROWS_W     = 4;
    localparam int START_W    = 16;
    localparam int LEN_W      = 17;

    // Queue between classifier and run tracker
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // Defaults for the top-level parameters
    localparam int MAX_COLS_DEF = 65536;
    localparam int MAX_ROWS_DEF = 8;

    // Classified column
    typedef struct packed {
        logic conserved;
        logic final_col;
    } t_col_item;

    // Queue head as seen by the back
    typedef struct packed {
        logic      valid;
        t_col_item item;
    } t_q_head;

endpackage

`default_nettype wire

/* sv/acs_front.sv */
// ============================================================================
// acs_front: column classifier
// Holds the row-count register and marks each incoming column conserved
// when all rows in use carry the same character.
// ============================================================================
`default_nettype none

module acs_front #(
    parameter int MAX_ROWS = acs_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_cfg_we,
    input  wire logic [acs_pkg::ROWS_W-1:0]                  i_cfg_wdata,
    input  wire logic [acs_pkg::ROW_FIELDS-1:0][acs_pkg::CHAR_W-1:0] i_chars,
    input  wire logic                                        i_final_column,
    output acs_pkg::t_col_item                               o_item
);
    import acs_pkg::*;

    localparam int ROW_CAP = (MAX_ROWS < ROW_FIELDS) ? MAX_ROWS : ROW_FIELDS;

    logic [ROWS_W-1:0] r_rows;
    logic [ROWS_W-1:0] n_rows;
    logic              w_cons;

    // Clamp the written row count into the usable range
    always_comb begin
        n_rows = r_rows;
        if (i_cfg_we) begin
            if (i_cfg_wdata > ROWS_W'(ROW_CAP)) begin
                n_rows = ROWS_W'(ROW_CAP);
            end else if (i_cfg_wdata < ROWS_W'(2)) begin
                n_rows = ROWS_W'(2);
            end else begin
                n_rows = i_cfg_wdata;
            end
        end
    end

    // Hold the row count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_W'(ROW_CAP);
        end else begin
            r_rows <= n_rows;
        end
    end

    // Compare every row in use against row 0
    always_comb begin
        w_cons = 1'b1;
        for (int r = 1; r < ROW_FIELDS; r++) begin
            if ((ROWS_W'(r) < r_rows) && (i_chars[r] != i_chars[0])) begin
                w_cons = 1'b0;
            end
        end
    end

    assign o_item.conserved = w_cons;
    assign o_item.final_col = i_final_column;

endmodule

`default_nettype wire

/* sv/acs_queue.sv */
// ============================================================================
// acs_queue: classified column queue
// Small register FIFO that decouples the classifier from the run tracker.
// ============================================================================
`default_nettype none

module acs_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire acs_pkg::t_col_item i_item,
    input  wire logic               i_pop,
    output logic                    o_full,
    output acs_pkg::t_q_head        o_head
);
    import acs_pkg::*;

    t_col_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr;
    logic [QPTR_W-1:0]     r_rd_ptr;
    logic [QCOUNT_W-1:0]   r_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_full      = (r_count == QCOUNT_W'(QDEPTH));
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCOUNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCOUNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/acs_back.sv */
// ============================================================================
// acs_back: run tracker
// Pops classified columns, extends or closes the open run and drives the
// registered result channel. A column that closes a run and is also final
// yields its second result in the following output slot.
// ============================================================================
`default_nettype none

module acs_back #(
    parameter int MAX_COLS = acs_pkg::MAX_COLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire acs_pkg::t_q_head              i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_conserved,
    output logic [acs_pkg::START_W-1:0]        o_run_start,
    output logic [acs_pkg::LEN_W-1:0]          o_run_length,
    output logic                               o_last_run
);
    import acs_pkg::*;

    localparam int IDX_LIM_I = (MAX_COLS - 1 > 65535) ? 65535 : MAX_COLS - 1;
    localparam int LEN_LIM_I = (MAX_COLS > 131071) ? 131071 : MAX_COLS;
    localparam logic [START_W-1:0] IDX_LIM = START_W'(IDX_LIM_I);
    localparam logic [LEN_W-1:0]   LEN_LIM = LEN_W'(LEN_LIM_I);

    // Run state
    logic               r_prev,  n_prev;
    logic               r_seen,  n_seen;
    logic [START_W-1:0] r_col,   n_col;
    logic [START_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic               r_pend,  n_pend;

    // Output register
    logic               r_ovalid, n_ovalid;
    logic               r_ocons,  n_ocons;
    logic [START_W-1:0] r_ostart, n_ostart;
    logic [LEN_W-1:0]   r_olen,   n_olen;
    logic               r_olast,  n_olast;

    logic               w_free;
    logic               w_closed;

    assign w_free = !r_ovalid || !i_stall;
    assign o_pop  = w_free && !r_pend && i_head.valid;

    // Update the run and pick the result for the next output slot
    always_comb begin
        n_prev   = r_prev;
        n_seen   = r_seen;
        n_col    = r_col;
        n_start  = r_start;
        n_len    = r_len;
        n_pend   = r_pend;
        n_ovalid = r_ovalid && i_stall;
        n_ocons  = r_ocons;
        n_ostart = r_ostart;
        n_olen   = r_olen;
        n_olast  = r_olast;
        w_closed = 1'b0;

        if (w_free) begin
            if (r_pend) begin
                // Flush the run opened by the final column
                n_ovalid = 1'b1;
                n_ocons  = r_prev;
                n_ostart = r_start;
                n_olen   = r_len;
                n_olast  = 1'b1;
                n_pend   = 1'b0;
                n_prev   = 1'b0;
                n_seen   = 1'b0;
                n_col    = '0;
                n_start  = '0;
                n_len    = '0;
            end else if (i_head.valid) begin
                if (!r_seen) begin
                    n_seen  = 1'b1;
                    n_prev  = i_head.item.conserved;
                    n_start = r_col;
                    n_len   = LEN_W'(1);
                end else if (i_head.item.conserved == r_prev) begin
                    if (r_len < LEN_LIM) begin
                        n_len = r_len + LEN_W'(1);
                    end
                end else begin
                    // Close the run on a change of kind
                    w_closed = 1'b1;
                    n_ovalid = 1'b1;
                    n_ocons  = r_prev;
                    n_ostart = r_start;
                    n_olen   = r_len;
                    n_olast  = 1'b0;
                    n_prev   = i_head.item.conserved;
                    n_start  = r_col;
                    n_len    = LEN_W'(1);
                end

                if (r_col < IDX_LIM) begin
                    n_col = r_col + START_W'(1);
                end

                if (i_head.item.final_col) begin
                    if (w_closed) begin
                        n_pend = 1'b1;
                    end else begin
                        n_ovalid = 1'b1;
                        n_ocons  = n_prev;
                        n_ostart = n_start;
                        n_olen   = n_len;
                        n_olast  = 1'b1;
                        n_prev   = 1'b0;
                        n_seen   = 1'b0;
                        n_col    = '0;
                        n_start  = '0;
                        n_len    = '0;
                    end
                end
            end
        end
    end

    // Hold run state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b0;
            r_seen   <= 1'b0;
            r_col    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_prev   <= n_prev;
            r_seen   <= n_seen;
            r_col    <= n_col;
            r_start  <= n_start;
            r_len    <= n_len;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
        r_ocons  <= n_ocons;
        r_ostart <= n_ostart;
        r_olen   <= n_olen;
        r_olast  <= n_olast;
    end

    assign o_valid      = r_ovalid;
    assign o_conserved  = r_ocons;
    assign o_run_start  = r_ostart;
    assign o_run_length = r_olen;
    assign o_last_run   = r_olast;

endmodule

`default_nettype wire

/* sv/alignment_column_run_segmenter.sv */
// ============================================================================
// alignment_column_run_segmenter: top level
// Splits a stream of alignment columns into runs of conserved or differing
// columns and reports each run as flag, start column and length.
// ============================================================================
//
//  Channel   Valid         Stall         Payload
//  -------   -----------   -----------   -----------------------------------
//  column    i_in_valid    o_in_stall    i_row_char_0..7, i_final_column
//  run       o_out_valid   i_out_stall   o_conserved, o_run_start,
//                                        o_run_length, o_last_run
//  config    i_cfg_we      -             i_cfg_wdata (rows in use)
//
//  One column is taken per cycle while the queue is not full; the run
//  tracker consumes one queued column per free output slot, so
//  throughput is one column per cycle unless i_out_stall holds the
//  output. A final column that also closes a run holds the tracker while
//  it sends its second result. Reset is synchronous, active low, and
//  clears queue and run state; the row count returns to MAX_ROWS, capped
//  at eight. o_in_stall rises only when the four-entry queue is full.
//
`default_nettype none

module alignment_column_run_segmenter #(
    parameter int MAX_COLS = acs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = acs_pkg::MAX_ROWS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [acs_pkg::ROWS_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [acs_pkg::CHAR_W-1:0]    i_row_char_0,
    input  wire logic [acs_pkg::CHAR_W-1:0]    i_row_char_1,
    input  wire logic [acs_pkg::CHAR_W-1:0]    i_row_char_2,
    input  wire logic [acs_pkg::CHAR_W-1:0]    i_row_char_3,
    input  wire logic [acs_pkg::CHAR_W-1:0]    i_row_char_4,
    input  wire logic [acs_pkg::CHAR_W-1:0]    i_row_char_5,
    input  wire logic [acs_pkg::CHAR_W-1:0]    i_row_char_6,
    input  wire logic [acs_pkg::CHAR_W-1:0]    i_row_char_7,
    input  wire logic                          i_final_column,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_conserved,
    output logic [acs_pkg::START_W-1:0]        o_run_start,
    output logic [acs_pkg::LEN_W-1:0]          o_run_length,
    output logic                               o_last_run
);
    import acs_pkg::*;

    localparam int LEN_LIM_I = (MAX_COLS > 131071) ? 131071 : MAX_COLS;

    logic [ROW_FIELDS-1:0][CHAR_W-1:0] w_chars;
    t_col_item                         w_item;
    t_q_head                           w_head;
    logic                              w_full;
    logic                              w_pop;

    // Gather the row characters
    assign w_chars[0] = i_row_char_0;
    assign w_chars[1] = i_row_char_1;
    assign w_chars[2] = i_row_char_2;
    assign w_chars[3] = i_row_char_3;
    assign w_chars[4] = i_row_char_4;
    assign w_chars[5] = i_row_char_5;
    assign w_chars[6] = i_row_char_6;
    assign w_chars[7] = i_row_char_7;

    assign o_in_stall = w_full;

    acs_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_chars        (w_chars),
        .i_final_column (i_final_column),
        .o_item         (w_item)
    );

    acs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    acs_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_conserved  (o_conserved),
        .o_run_start  (o_run_start),
        .o_run_length (o_run_length),
        .o_last_run   (o_last_run)
    );

    // Every reported run holds at least one column
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_length != '0))
        else $error("run reported with zero length");

    // Run length never passes its saturation limit
    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_length <= LEN_W'(LEN_LIM_I)))
        else $error("run length above limit");

    // The tracker pops only when the queue has an entry
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

    // A result taken leaves the output free unless a new one was loaded
    a_out_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !w_head.valid && !w_pop) |=>
        (!o_out_valid || $past(o_last_run) == 1'b0))
        else $error("output advanced without a source");

endmodule

`default_nettype wire
